FILE: hdl/gbt_pkg.sv
// ----------------------------------------------------------------------------
// gbt_pkg
// shared command codes, status codes and a few narrow types
// ----------------------------------------------------------------------------
package gbt_pkg;

  typedef enum logic [2:0] {
    FUNC_NEW  = 3'd0,
    FUNC_EDGE = 3'd1,
    FUNC_VERT = 3'd2,
    FUNC_BFS  = 3'd3,
    FUNC_DFS  = 3'd4
  } func_t;

  typedef enum logic [1:0] {
    ST_OK    = 2'd0,
    ST_RANGE = 2'd1,
    ST_FULL  = 2'd2,
    ST_LIMIT = 2'd3
  } status_t;

  localparam int VW = 7;

  typedef logic [VW-1:0] vert_t;

endpackage

FILE: hdl/graph_bfs_dfs_traversal.sv
// ----------------------------------------------------------------------------
// graph_bfs_dfs_traversal
// directed graph store with breadth-first and depth-first walks
// ----------------------------------------------------------------------------
// build commands: one result item in the cycle after acceptance, one per cycle while idle
// a walk first clears the marks of the current vertices, then scans the edge
// store (one read port) once per visited vertex; on a source match it also
// reads the visited mark of the edge target
// busy is high during a walk, up to its last result item; build commands keep it low; results cannot stall
// synchronous reset clears counts and control; memories stay as they are
module graph_bfs_dfs_traversal #(
  parameter int MAX_VERTICES = 64,
  parameter int MAX_EDGES    = 256
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [2:0]        func,
  input  gbt_pkg::vert_t    vertex_a,
  input  gbt_pkg::vert_t    vertex_b,
  input  gbt_pkg::vert_t    vertex_total,
  input  logic              direction,
  output logic              strobe,
  output gbt_pkg::vert_t    vertex,
  output logic              last,
  output logic [1:0]        status
);
  import gbt_pkg::*;

  localparam int EW = $clog2(MAX_EDGES);
  localparam int CW = $clog2(MAX_EDGES + 1);
  localparam int SW = $clog2(MAX_VERTICES);
  localparam int DW = $clog2(MAX_VERTICES + 1);

  typedef enum logic [11:0] {
    S_IDLE  = 12'b000000000001,
    S_START = 12'b000000000010,  // search for next unvisited start vertex
    S_POP   = 12'b000000000100,  // read walk store top / head
    S_POPW  = 12'b000000001000,  // walk store data lands
    S_SCAN  = 12'b000000010000,  // issue edge read
    S_CHK   = 12'b000000100000,  // edge data lands, test target
    S_DONE  = 12'b000001000000,
    S_MARK  = 12'b000010000000,  // wait on walk store write
    S_NEXT  = 12'b000100000000,
    S_CLR   = 12'b001000000000,  // clear visited marks, one vertex a cycle
    S_STW   = 12'b010000000000,  // visited mark of start candidate lands
    S_VIS   = 12'b100000000000   // visited mark of edge target lands
  } state_t;

  state_t state;

  // edge memory: one entry per stored edge, source and target packed
  logic [2*VW-1:0] edge_mem [MAX_EDGES];
  logic [2*VW-1:0] edge_q;
  logic [EW-1:0]   edge_raddr;
  logic            edge_we;
  logic [EW-1:0]   edge_waddr;
  logic [2*VW-1:0] edge_wdata;

  always_ff @(posedge clk) begin
    if (edge_we) edge_mem[edge_waddr] <= edge_wdata;
    edge_q <= edge_mem[edge_raddr];
  end

  // walk store: vertex plus dfs resume position
  logic [VW+CW-1:0] walk_mem [MAX_VERTICES];
  logic [VW+CW-1:0] walk_q;
  logic [SW-1:0]    walk_raddr;
  logic             walk_we;
  logic [SW-1:0]    walk_waddr;
  logic [VW+CW-1:0] walk_wdata;

  always_ff @(posedge clk) begin
    if (walk_we) walk_mem[walk_waddr] <= walk_wdata;
    walk_q <= walk_mem[walk_raddr];
  end

  // visited marks, vertex v at address v-1, cleared at the start of each walk
  logic          vis_mem [MAX_VERTICES];
  logic          vis_q;
  logic [SW-1:0] vis_raddr;
  logic          vis_we;
  logic [SW-1:0] vis_waddr;
  logic          vis_wdata;

  always_ff @(posedge clk) begin
    if (vis_we) vis_mem[vis_waddr] <= vis_wdata;
    vis_q <= vis_mem[vis_raddr];
  end

  logic [DW-1:0] vertex_count;
  logic [CW-1:0] edge_count;
  logic          is_bfs;
  logic [DW-1:0] scan_s;     // next start candidate, also the clear pointer
  logic [DW-1:0] head, tail; // bfs queue / dfs depth in tail
  vert_t         cur_v;
  logic [CW-1:0] e_idx;
  vert_t         pend_v;     // held result, last bit known later
  logic          pend;

  logic          in_a, in_b;
  assign in_a = (vertex_a >= VW'(1)) && ({1'b0, vertex_a} <= (VW+1)'(vertex_count));
  assign in_b = (vertex_b >= VW'(1)) && ({1'b0, vertex_b} <= (VW+1)'(vertex_count));

  vert_t tgt, src;
  assign src = edge_q[2*VW-1:VW];
  assign tgt = edge_q[VW-1:0];
  logic tgt_in;
  assign tgt_in = (tgt >= VW'(1)) && ({1'b0, tgt} <= (VW+1)'(vertex_count));

  assign busy = (state != S_IDLE);

  always_comb begin
    edge_raddr = e_idx[EW-1:0];
    walk_raddr = is_bfs ? head[SW-1:0] : SW'(tail - DW'(1));
    vis_raddr  = (state == S_START) ? SW'(scan_s - DW'(1)) : SW'(tgt - VW'(1));
  end

  // emit pending item before storing a new one; last is set at walk end
  task automatic push_out(input vert_t v);
    if (pend) begin
      strobe <= 1'b1;
      vertex <= pend_v;
      last   <= 1'b0;
      status <= ST_OK;
    end
    pend   <= 1'b1;
    pend_v <= v;
  endtask

  always_ff @(posedge clk) begin
    strobe  <= 1'b0;
    edge_we <= 1'b0;
    walk_we <= 1'b0;
    vis_we  <= 1'b0;
    if (rst) begin
      state        <= S_IDLE;
      vertex_count <= '0;
      edge_count   <= '0;
      pend         <= 1'b0;
      edge_waddr   <= '0;
      walk_waddr   <= '0;
      vis_waddr    <= '0;
    end else begin
      case (state)
        S_IDLE: begin
          if (start) begin
            vertex <= '0;
            last   <= 1'b1;
            status <= ST_OK;
            case (func)
              FUNC_NEW: begin
                strobe <= 1'b1;
                if (vertex_total > VW'(MAX_VERTICES)) status <= ST_LIMIT;
                else begin
                  vertex_count <= DW'(vertex_total);
                  edge_count   <= '0;
                end
              end
              FUNC_EDGE: begin
                strobe <= 1'b1;
                if (!in_a || !in_b) status <= ST_RANGE;
                else if (edge_count >= CW'(MAX_EDGES)) status <= ST_FULL;
                else begin
                  edge_we    <= 1'b1;
                  edge_waddr <= edge_count[EW-1:0];
                  edge_wdata <= {vertex_a, vertex_b};
                  edge_count <= edge_count + CW'(1);
                end
              end
              FUNC_VERT: begin
                strobe <= 1'b1;
                if (!in_a) status <= ST_RANGE;
                else if (vertex_count >= DW'(MAX_VERTICES)) status <= ST_LIMIT;
                else if (edge_count >= CW'(MAX_EDGES)) status <= ST_FULL;
                else begin
                  vertex_count <= vertex_count + DW'(1);
                  edge_we      <= 1'b1;
                  edge_waddr   <= edge_count[EW-1:0];
                  edge_wdata   <= direction ?
                                  {VW'(vertex_count + DW'(1)), vertex_a} :
                                  {vertex_a, VW'(vertex_count + DW'(1))};
                  edge_count   <= edge_count + CW'(1);
                end
              end
              FUNC_BFS, FUNC_DFS: begin
                is_bfs  <= (func == FUNC_BFS);
                scan_s  <= DW'(1);
                pend    <= 1'b0;
                state   <= S_CLR;
              end
              default: ;
            endcase
          end
        end
        S_CLR: begin
          if (scan_s > vertex_count) begin
            scan_s <= DW'(1);
            state  <= S_START;
          end else begin
            vis_we    <= 1'b1;
            vis_waddr <= SW'(scan_s - DW'(1));
            vis_wdata <= 1'b0;
            scan_s    <= scan_s + DW'(1);
          end
        end
        S_START: begin
          if (scan_s > vertex_count) state <= S_DONE;
          else state <= S_STW;
        end
        S_STW: begin
          if (vis_q) begin
            scan_s <= scan_s + DW'(1);
            state  <= S_START;
          end else begin
            vis_we     <= 1'b1;
            vis_waddr  <= SW'(scan_s - DW'(1));
            vis_wdata  <= 1'b1;
            walk_we    <= 1'b1;
            walk_waddr <= '0;
            walk_wdata <= {VW'(scan_s), CW'(0)};
            head       <= '0;
            tail       <= DW'(1);
            if (!is_bfs) push_out(VW'(scan_s));
            scan_s     <= scan_s + DW'(1);
            state      <= S_MARK;
          end
        end
        S_MARK: state <= S_POP;  // let the walk store write settle
        S_POP: begin
          if (is_bfs ? (head == tail) : (tail == '0)) state <= S_START;
          else state <= S_POPW;
        end
        S_POPW: begin
          cur_v <= walk_q[VW+CW-1:CW];
          e_idx <= is_bfs ? CW'(0) : walk_q[CW-1:0];
          if (is_bfs) begin
            push_out(walk_q[VW+CW-1:CW]);
            head <= head + DW'(1);
          end
          state <= S_SCAN;
        end
        S_SCAN: begin
          if (e_idx >= edge_count) begin
            if (!is_bfs) tail <= tail - DW'(1);
            state <= S_POP;
          end else state <= S_CHK;
        end
        S_CHK: begin
          // visited mark of the target is read here, lands in the next cycle
          if (src == cur_v && tgt_in && tail < DW'(MAX_VERTICES)) state <= S_VIS;
          else begin
            e_idx <= e_idx + CW'(1);
            state <= S_SCAN;
          end
        end
        S_VIS: begin
          if (!vis_q) begin
            vis_we    <= 1'b1;
            vis_waddr <= SW'(tgt - VW'(1));
            vis_wdata <= 1'b1;
            walk_we   <= 1'b1;
            if (is_bfs) begin
              walk_waddr <= tail[SW-1:0];
              walk_wdata <= {tgt, CW'(0)};
              tail       <= tail + DW'(1);
              e_idx      <= e_idx + CW'(1);
              state      <= S_NEXT;
            end else begin
              // save resume point of parent, then push child
              walk_waddr <= SW'(tail - DW'(1));
              walk_wdata <= {cur_v, e_idx + CW'(1)};
              push_out(tgt);
              cur_v <= tgt;
              e_idx <= '0;
              state <= S_NEXT;
            end
          end else begin
            e_idx <= e_idx + CW'(1);
            state <= S_SCAN;
          end
        end
        S_NEXT: begin
          if (!is_bfs) begin
            walk_we    <= 1'b1;
            walk_waddr <= tail[SW-1:0];
            walk_wdata <= {cur_v, CW'(0)};
            tail       <= tail + DW'(1);
          end
          state <= S_SCAN;
        end
        S_DONE: begin
          strobe <= 1'b1;
          last   <= 1'b1;
          status <= ST_OK;
          vertex <= pend ? pend_v : '0;
          pend   <= 1'b0;
          state  <= S_IDLE;
        end
        default: state <= S_IDLE;
      endcase
    end
  end

endmodule
